// ===== design/assert_macros.svh =====
// Assertion macros shared by the deque RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define DQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("deque assertion failed");
// Expression must never be true outside reset.
`define DQ_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("deque forbidden condition seen");
`else
`define DQ_ASSERT(lbl, clk, rstn, prop)
`define DQ_ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ===== design/dq_pkg.sv =====
// Package for the double-ended queue: sizes, operation and status codes, cell control.
package dq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // Broadcast shift control for the row of cells.
    typedef struct packed {
        logic shift_right;  // toward the back: push at the front
        logic shift_left;   // toward the front: pop at the front
    } cell_cmd_t;

endpackage

// ===== design/dq_cell.sv =====
// One storage cell of the deque row: holds a word, shifts to either neighbor or loads.
module dq_cell
    import dq_pkg::*;
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic                     load,
    input  logic signed [DATA_W-1:0] load_data,
    input  logic signed [DATA_W-1:0] left_data,
    input  logic signed [DATA_W-1:0] right_data,
    output logic signed [DATA_W-1:0] data
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        priority if (cmd.shift_right)
            data_next = left_data;
        else if (cmd.shift_left)
            data_next = right_data;
        else if (load)
            data_next = load_data;
        else
            data_next = data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== design/double_ended_queue.sv =====
// Top level of the double-ended queue: control, count, row of cells and result register.
//
// Double-ended queue of signed 32-bit words, DEPTH entries deep.
// Input channel (in_valid/in_ready): one beat carries func (push front,
// push back, pop front, pop back) and push_value (ignored on pops).
// Output channel (out_valid/out_ready): exactly one beat per input beat,
// with pop_value (0 on pushes, -1 on underflow), status and the occupancy
// after the operation.
// Storage is a row of cells; entry 0 is always the front. Push front shifts
// the whole row one cell back in the accepting cycle, pop front shifts it
// one cell forward, push back loads the cell at the current count and pop
// back reads the cell just below the count.
// The result is registered and appears in the cycle after the input beat is accepted.
// Throughput: one item per cycle; the single result register frees up in
// the same cycle its beat is taken, so in_ready = !out_valid || out_ready.
// When the receiver stalls, the held result blocks further input.
// A push on a full queue or a pop on an empty one changes neither the count nor the cells.
// Reset (rst_n low, asynchronous) empties the queue and the result register;
// the cell contents are left as they are and never read before written.
`include "assert_macros.svh"
module double_ended_queue
    import dq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               func,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] pop_value,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         occupancy
);

    // Control state
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    // Result payload
    logic signed [DATA_W-1:0] pop_value_reg;
    logic signed [DATA_W-1:0] pop_value_next;
    status_t                  status_reg;
    status_t                  status_next;

    logic      in_fire;
    op_t       op;
    logic      is_push;
    logic      full;
    logic      empty;
    logic      do_op;
    cell_cmd_t cmd;
    logic [IDX_W-1:0] tail_idx;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]         cell_load;

    assign op       = op_t'(func);
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_push  = (op == OP_PUSH_FRONT) || (op == OP_PUSH_BACK);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    // Dropped push on full, failed pop on empty: state untouched.
    assign do_op    = in_fire && (is_push ? !full : !empty);

    // Slot of the back entry; only used when the queue is not empty.
    assign tail_idx = IDX_W'(count_reg - CNT_W'(1));

    assign cmd.shift_right = do_op && (op == OP_PUSH_FRONT);
    assign cmd.shift_left  = do_op && (op == OP_POP_FRONT);

    // Row of cells; cell 0 takes the new front word on a push at the front.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_in;
            logic signed [DATA_W-1:0] right_in;

            assign cell_load[gi] = do_op && (op == OP_PUSH_BACK) &&
                                   (count_reg == CNT_W'(gi));

            if (gi == 0)
            begin : g_first
                assign left_in = push_value;
            end
            else
            begin : g_mid
                assign left_in = cell_data[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_in = '0;
            end
            else
            begin : g_inner
                assign right_in = cell_data[gi+1];
            end

            dq_cell u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .load       (cell_load[gi]),
                .load_data  (push_value),
                .left_data  (left_in),
                .right_data (right_in),
                .data       (cell_data[gi])
            );
        end
    endgenerate

    // Count update
    always_comb
    begin
        count_next = count_reg;
        if (do_op)
        begin
            if (is_push)
                count_next = count_reg + CNT_W'(1);
            else
                count_next = count_reg - CNT_W'(1);
        end
    end

    // Result word and status for the accepted beat
    always_comb
    begin
        pop_value_next = '0;
        status_next    = ST_OK;
        unique case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (full)
                    status_next = ST_OVERFLOW;
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    pop_value_next = '1;
                    status_next    = ST_UNDERFLOW;
                end
                else
                    pop_value_next = cell_data[0];
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    pop_value_next = '1;
                    status_next    = ST_UNDERFLOW;
                end
                else
                    pop_value_next = cell_data[tail_idx];
            end
            default:
            begin
                pop_value_next = '0;
                status_next    = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload register: loaded on every accepted beat
    logic [CNT_W-1:0] occupancy_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pop_value_reg <= pop_value_next;
            status_reg    <= status_next;
            occupancy_reg <= count_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

    // Checks
    `DQ_ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > CNT_W'(DEPTH))
    `DQ_ASSERT(a_fire_gives_result, clk, rst_n, in_fire |=> out_valid_reg)
    `DQ_ASSERT(a_push_grows, clk, rst_n, (in_fire && is_push && !full) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
    `DQ_ASSERT(a_underflow_holds, clk, rst_n, (in_fire && !is_push && empty) |=> (status_reg == ST_UNDERFLOW && count_reg == '0 && occupancy_reg == '0))
    `DQ_ASSERT(a_result_occupancy, clk, rst_n, in_fire |=> (occupancy_reg == count_reg))

endmodule

// ===== test/deque_checker.sv =====
// Deque checker: predicts each result beat from the input beats and compares it field by field.
module deque_checker
    import dq_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [1:0]               func,
    input  logic signed [DATA_W-1:0] push_value,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [DATA_W-1:0] pop_value,
    input  logic [1:0]               status,
    input  logic [CNT_W-1:0]         occupancy,
    output int                       error_count,
    output int                       outstanding
);

    typedef struct {
        logic signed [DATA_W-1:0] word;
        status_t                  code;
        logic [CNT_W-1:0]         fill;
    } deque_result_t;

    // Predicted deque: ring of words, front slot, slot past the back, entry count.
    logic signed [DATA_W-1:0] ring [DEPTH];
    int                       head;
    int                       tail;
    int                       held;

    deque_result_t awaited[$];
    deque_result_t want;
    int            errors;

    function automatic deque_result_t apply_op(op_t op, logic signed [DATA_W-1:0] word);
        deque_result_t r;
        r.word = '0;
        r.code = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (held == DEPTH)
                    r.code = ST_OVERFLOW;
                else if (op == OP_PUSH_FRONT)
                begin
                    head = (head == 0) ? DEPTH - 1 : head - 1;
                    ring[head] = word;
                    held++;
                end
                else
                begin
                    ring[tail] = word;
                    tail = (tail == DEPTH - 1) ? 0 : tail + 1;
                    held++;
                end
            end
            default:
            begin
                if (held == 0)
                begin
                    r.word = -1;
                    r.code = ST_UNDERFLOW;
                end
                else if (op == OP_POP_FRONT)
                begin
                    r.word = ring[head];
                    head = (head == DEPTH - 1) ? 0 : head + 1;
                    held--;
                end
                else
                begin
                    tail = (tail == 0) ? DEPTH - 1 : tail - 1;
                    r.word = ring[tail];
                    held--;
                end
            end
        endcase
        r.fill = CNT_W'(held);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head = 0;
            tail = 0;
            held = 0;
            errors = 0;
            awaited.delete();
            error_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Result beat first: it always belongs to an earlier input beat.
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: unexpected result beat pop_value %0d status %0d occupancy %0d",
                             $time, pop_value, status, occupancy);
                    errors++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (pop_value !== want.word)
                    begin
                        $display("%0t: pop_value mismatch, expected %0d, actual %0d",
                                 $time, want.word, pop_value);
                        errors++;
                    end
                    if (status !== want.code)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.code, status);
                        errors++;
                    end
                    if (occupancy !== want.fill)
                    begin
                        $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                                 $time, want.fill, occupancy);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
                awaited.push_back(apply_op(op_t'(func), push_value));
            outstanding <= awaited.size();
            error_count <= errors;
        end
    end

endmodule

// ===== test/double_ended_queue_tb.sv =====
// Testbench top for the double-ended queue: clock, reset, beat stimulus, stalls and verdict.
module double_ended_queue_tb;
    import dq_pkg::*;

    localparam int RANDOM_ITEMS = 1626;
    localparam int DRAIN_LIMIT  = 5000;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic [1:0]               func       = OP_PUSH_FRONT;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         occupancy;

    int error_count;
    int outstanding;

    // Calm stretches switch off idling on one side for a while.
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    int stall_left  = 0;
    int rx_run_left = 0;

    double_ended_queue u_top (.*);

    // Watches both channels, keeps its own deque and counts mismatches.
    deque_checker u_check (.*);

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Idle length: mostly none or short, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Push data: extremes show up often, the rest is a full random word.
    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return -1;
            3:       return 0;
            default: return $urandom;
        endcase
    endfunction

    // Called at a rising edge. Optional gap with valid low, then hold the beat
    // until accepted. in_ready is sampled at the falling edge, where it is
    // settled; it cannot change again before the next rising edge.
    task automatic send_beat(input op_t op, input logic signed [DATA_W-1:0] word);
        int   gap;
        logic took;
        gap = tx_calm ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= op;
        push_value <= word;
        do
        begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    // Stop sending and wait for every predicted result to come back, with a bound.
    task automatic drain(input int limit);
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < limit);
        @(posedge clk);
    endtask

    // Receiver: random stalls on out_ready, one assignment per edge.
    always @(posedge clk)
    begin
        if (rx_run_left == 0)
        begin
            rx_run_left = $urandom_range(20, 200);
            rx_calm = ($urandom_range(0, 4) == 0);
        end
        rx_run_left--;
        if (stall_left == 0 && !rx_calm)
            stall_left = idle_len();
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        int  push_pct;
        int  burst_left;
        op_t op;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pops on an empty deque from both ends (push_value ignored).
        send_beat(OP_POP_FRONT, 32'sd5);
        send_beat(OP_POP_BACK, -32'sd7);
        // Extremes in, then out from the same ends they went in at.
        send_beat(OP_PUSH_BACK, 32'h7fff_ffff);
        send_beat(OP_PUSH_FRONT, 32'h8000_0000);
        send_beat(OP_POP_BACK, '0);
        send_beat(OP_POP_FRONT, '0);
        // Fill to the top from both ends; front pushes wrap the front slot
        // below zero. A stored -1 looks like the underflow answer.
        for (int i = 0; i < DEPTH; i++)
            send_beat(i[0] ? OP_PUSH_BACK : OP_PUSH_FRONT,
                      (i == 0) ? -1 : (i == 1) ? 0 : rand_word());
        // Both pushes on a full deque get dropped.
        send_beat(OP_PUSH_FRONT, 32'sd1);
        send_beat(OP_PUSH_BACK, 32'sd2);
        drain(DRAIN_LIMIT);

        // Random bursts: push-heavy ones fill the deque and hit overflow,
        // pop-heavy ones empty it and hit underflow, the rest wander.
        burst_left = 0;
        push_pct   = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(8, 60);
                case ($urandom_range(0, 3))
                    0:       push_pct = 85;
                    1:       push_pct = 15;
                    2:       push_pct = 50;
                    default: push_pct = $urandom_range(0, 100);
                endcase
                tx_calm = ($urandom_range(0, 4) == 0);
            end
            burst_left--;
            // Sender holds off mid-run until the result side has caught up.
            if (n == RANDOM_ITEMS / 2)
                drain(DRAIN_LIMIT);
            if ($urandom_range(1, 100) <= push_pct)
                op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            send_beat(op, rand_word());
        end

        drain(DRAIN_LIMIT);
        // A few more cycles so a stray beat after the last one gets caught.
        repeat (4) @(posedge clk);
        @(negedge clk);
        if (outstanding != 0)
            $display("%0t: %0d result beats never arrived", $time, outstanding);
        if (error_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
